/* design/length_prefixed_arg_parser_core_assert.svh */
// Assertion macros shared by the parser modules.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef LENGTH_PREFIXED_ARG_PARSER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_ARG_PARSER_CORE_ASSERT_SVH

// Check a same-cycle implication outside reset.
`define LPAP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpap: same-cycle check failed");

// Check an implication in the next cycle outside reset.
`define LPAP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lpap: next-cycle check failed");

`endif

/* design/lpap_pkg.sv */
// Types and constants of the length-prefixed argument parser.
// No dependencies; imported by every module of the block.
package lpap_pkg;

   localparam int unsigned FIELD_BYTES = 4;
   localparam int unsigned POS_W = $clog2(FIELD_BYTES);
   localparam logic [31:0] ARG_LIMIT_RESET = 32'd200000;

   // Parse phase of the current request
   typedef enum logic [1:0] {
      PH_COUNT = 2'd0,
      PH_LEN   = 2'd1,
      PH_DATA  = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   // Verdict reported with each result
   typedef enum logic [1:0] {
      ST_BUSY   = 2'd0,
      ST_ACCEPT = 2'd1,
      ST_REJECT = 2'd2
   } status_type;

   // One result transaction
   typedef struct packed {
      logic [7:0]  arg_byte;
      logic        arg_byte_valid;
      logic [31:0] arg_index;
      logic        arg_end;
      status_type  status;
   } rsp_item_type;

endpackage

/* design/lpap_if.sv */
// Channel interfaces of the parser: request bytes, results, register writes.
// Depends on nothing; used by all modules of the block.
interface lpap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lpap_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  arg_byte;
   logic        arg_byte_valid;
   logic [31:0] arg_index;
   logic        arg_end;
   logic [1:0]  status;
   modport source (output valid, output arg_byte, output arg_byte_valid,
                   output arg_index, output arg_end, output status, input ready);
   modport sink (input valid, input arg_byte, input arg_byte_valid,
                 input arg_index, input arg_end, input status, output ready);
endinterface

interface lpap_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* design/lpap_parse.sv */
// Parse state machine: field assembly, argument counting and verdict.
// Depends on lpap_pkg, lpap_if and the assertion macro header.
`include "length_prefixed_arg_parser_core_assert.svh"

module lpap_parse
   import lpap_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   lpap_req_if.sink      req,
   lpap_csr_if.sink      csr,
   input  logic          can_take,
   output logic          item_fire,
   output rsp_item_type  res
);

   phase_type        phase_ff, phase_in, step_phase;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [23:0]      accum_ff, accum_in;
   logic [31:0]      expected_ff, expected_in;
   logic [31:0]      done_ff, done_in;
   logic [31:0]      left_ff, left_in;
   logic             failed_ff, failed_in, step_failed;
   logic [31:0]      arg_limit_ff;

   logic [31:0] field_full;
   logic        field_last;
   logic [31:0] done_inc;
   logic        finish_all;
   logic [23:0] lane_byte;

   assign req.ready  = can_take;
   assign csr.ready  = 1'b1;
   assign item_fire  = req.valid && can_take;

   // Assemble the little-endian field; the fourth byte completes it directly
   assign field_last = (pos_ff == POS_W'(FIELD_BYTES - 1));
   assign field_full = {req.data_byte, accum_ff};
   assign lane_byte  = 24'(req.data_byte) << {pos_ff, 3'b000};
   assign done_inc   = done_ff + 32'd1;
   assign finish_all = (done_inc == expected_ff);

   // Next state
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      accum_in    = accum_ff;
      expected_in = expected_ff;
      done_in     = done_ff;
      left_in     = left_ff;
      failed_in   = failed_ff;
      if (item_fire && !failed_ff) begin
         case (phase_ff)
            PH_COUNT, PH_LEN: begin
               if (field_last) begin
                  pos_in   = '0;
                  accum_in = '0;
                  if (phase_ff == PH_COUNT) begin
                     if (field_full > arg_limit_ff) begin
                        failed_in = 1'b1;
                     end else begin
                        expected_in = field_full;
                        done_in     = '0;
                        phase_in    = (field_full == 32'd0) ? PH_DONE : PH_LEN;
                     end
                  end else begin
                     left_in = field_full;
                     if (field_full == 32'd0) begin
                        done_in  = done_inc;
                        phase_in = finish_all ? PH_DONE : PH_LEN;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end else begin
                  pos_in   = pos_ff + POS_W'(1);
                  accum_in = accum_ff | lane_byte;
               end
            end
            PH_DATA: begin
               left_in = left_ff - 32'd1;
               if (left_ff == 32'd1) begin
                  done_in  = done_inc;
                  phase_in = finish_all ? PH_DONE : PH_LEN;
               end
            end
            default: begin
               // a byte after the final argument
               failed_in = 1'b1;
            end
         endcase
      end
      step_phase  = phase_in;
      step_failed = failed_in;
      // Rearm after the last byte of a request
      if (item_fire && req.last_byte) begin
         phase_in    = PH_COUNT;
         pos_in      = '0;
         accum_in    = '0;
         expected_in = '0;
         done_in     = '0;
         left_in     = '0;
         failed_in   = 1'b0;
      end
   end

   // Result fields
   always_comb begin
      res = '0;
      res.status = ST_BUSY;
      if (!failed_ff) begin
         case (phase_ff)
            PH_LEN: begin
               if (field_last && field_full == 32'd0) begin
                  res.arg_end   = 1'b1;
                  res.arg_index = done_ff;
               end
            end
            PH_DATA: begin
               res.arg_byte       = req.data_byte;
               res.arg_byte_valid = 1'b1;
               res.arg_index      = done_ff;
               res.arg_end        = (left_ff == 32'd1);
            end
            default: begin
               res.arg_end = 1'b0;
            end
         endcase
      end
      if (req.last_byte) begin
         res.status = (step_failed || step_phase != PH_DONE) ? ST_REJECT : ST_ACCEPT;
      end
   end

   // Hold parse state; advance on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COUNT;
         pos_ff       <= '0;
         accum_ff     <= '0;
         expected_ff  <= '0;
         done_ff      <= '0;
         left_ff      <= '0;
         failed_ff    <= 1'b0;
         arg_limit_ff <= ARG_LIMIT_RESET;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         accum_ff    <= accum_in;
         expected_ff <= expected_in;
         done_ff     <= done_in;
         left_ff     <= left_in;
         failed_ff   <= failed_in;
         if (csr.valid) begin
            arg_limit_ff <= csr.data;
         end
      end
   end

   `LPAP_ASSERT_NOW(a_failed_silent, item_fire && failed_ff, !res.arg_byte_valid && !res.arg_end)
   `LPAP_ASSERT_NOW(a_busy_midway, item_fire && !req.last_byte, res.status == ST_BUSY)
   `LPAP_ASSERT_NEXT(a_rearm, item_fire && req.last_byte, phase_ff == PH_COUNT && !failed_ff)

endmodule

/* design/lpap_out_reg.sv */
// Result register between the parse logic and the result channel.
// Depends on lpap_pkg, lpap_if and the assertion macro header.
`include "length_prefixed_arg_parser_core_assert.svh"

module lpap_out_reg
   import lpap_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rsp_item_type  res,
   output logic          can_take,
   lpap_rsp_if.source    rsp
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   // Take a new result when empty or when the held one leaves this cycle
   assign can_take = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = res;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp.valid          = valid_ff;
   assign rsp.arg_byte       = item_ff.arg_byte;
   assign rsp.arg_byte_valid = item_ff.arg_byte_valid;
   assign rsp.arg_index      = item_ff.arg_index;
   assign rsp.arg_end        = item_ff.arg_end;
   assign rsp.status         = item_ff.status;

   `LPAP_ASSERT_NEXT(a_load_shows, load, valid_ff)
   `LPAP_ASSERT_NOW(a_idle_byte_zero, valid_ff && !item_ff.arg_byte_valid, item_ff.arg_byte == 8'd0)
   `LPAP_ASSERT_NOW(a_idle_index_zero, valid_ff && !item_ff.arg_byte_valid && !item_ff.arg_end, item_ff.arg_index == 32'd0)

endmodule

/* design/length_prefixed_arg_parser_core.sv */
// Top level of the length-prefixed argument parser.
// Depends on lpap_pkg, lpap_if, lpap_parse and lpap_out_reg.
//
//   channel   direction  payload                                          role
//   req_chan  in         data_byte, last_byte                             request bytes
//   rsp_chan  out        arg_byte, arg_byte_valid, arg_index, arg_end,    one result per byte
//                        status
//   csr_chan  in         data                                             argument limit write
//
// One request byte is accepted per clock while the result register can take it; its result appears in the next cycle.
// The parse state update and result are one combinational step into the result register.
// A stalled result register blocks new bytes only while rsp_chan is not ready.
// Synchronous reset sets the argument limit to 200000 and the parser to await a count.
// csr_chan is always ready; write it only while the block is idle.
module length_prefixed_arg_parser_core
   import lpap_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   lpap_req_if.sink      req_chan,
   lpap_rsp_if.source    rsp_chan,
   lpap_csr_if.sink      csr_chan
);

   logic         can_take;
   logic         item_fire;
   rsp_item_type res;

   lpap_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .csr       (csr_chan),
      .can_take  (can_take),
      .item_fire (item_fire),
      .res       (res)
   );

   lpap_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (item_fire),
      .res      (res),
      .can_take (can_take),
      .rsp      (rsp_chan)
   );

endmodule

/* tb/length_prefixed_arg_parser_core_tb.sv */
// Testbench for length_prefixed_arg_parser_core: random request streams checked per byte.
// Depends on lpap_pkg and the lpap_req_if, lpap_rsp_if and lpap_csr_if interfaces.
`timescale 1ns / 100ps

module length_prefixed_arg_parser_core_tb;
   import lpap_pkg::*;

   // How a generated request is bent away from a well-formed one
   typedef enum logic [1:0] {
      SHAPE_WELL  = 2'd0,
      SHAPE_CUT   = 2'd1,
      SHAPE_TRAIL = 2'd2,
      SHAPE_NOISE = 2'd3
   } req_shape_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_byte_type;

   logic clock;
   logic reset;

   lpap_req_if req_if ();
   lpap_rsp_if rsp_if ();
   lpap_csr_if csr_if ();

   length_prefixed_arg_parser_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   req_byte_type request_bytes[$];
   rsp_item_type parsed_items[$];
   int unsigned  mismatch_count;
   int unsigned  bytes_queued;
   logic [31:0]  cur_arg_limit;

   // Idle controls, changed only between phases
   logic send_bursty;
   logic recv_stalls;

   // Parser image
   phase_type   parse_phase;
   logic [1:0]  field_pos;
   logic [31:0] field_acc;
   logic [31:0] args_wanted;
   logic [31:0] args_seen;
   logic [31:0] data_left;
   logic        req_failed;
   logic [31:0] arg_limit_reg;

   // Sender burst state and receiver stall pattern
   int unsigned burst_left;
   int unsigned gap_left;
   logic [15:0] stall_pattern;
   logic [4:0]  pattern_age;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void rearm_parse();
      parse_phase = PH_COUNT;
      field_pos   = '0;
      field_acc   = '0;
      args_wanted = '0;
      args_seen   = '0;
      data_left   = '0;
      req_failed  = 1'b0;
   endfunction

   // Shift one byte into the little-endian field; true when four bytes are in
   function automatic logic take_field_byte(logic [7:0] b);
      field_acc = field_acc | (32'(b) << (8 * field_pos));
      field_pos = field_pos + 2'd1;
      return field_pos == 2'd0;
   endfunction

   function automatic void close_argument();
      args_seen   = args_seen + 32'd1;
      parse_phase = (args_seen == args_wanted) ? PH_DONE : PH_LEN;
   endfunction

   // Advance the parser image by one request byte and return its result
   function automatic rsp_item_type parse_request_byte(logic [7:0] b, logic last);
      rsp_item_type r;
      logic [31:0]  n;
      r = '0;
      r.status = ST_BUSY;
      if (!req_failed) begin
         case (parse_phase)
            PH_COUNT: begin
               if (take_field_byte(b)) begin
                  n = field_acc;
                  field_acc = '0;
                  if (n > arg_limit_reg) begin
                     req_failed = 1'b1;
                  end else begin
                     args_wanted = n;
                     args_seen   = '0;
                     parse_phase = (n == 32'd0) ? PH_DONE : PH_LEN;
                  end
               end
            end
            PH_LEN: begin
               if (take_field_byte(b)) begin
                  data_left = field_acc;
                  field_acc = '0;
                  if (data_left == 32'd0) begin
                     r.arg_end   = 1'b1;
                     r.arg_index = args_seen;
                     close_argument();
                  end else begin
                     parse_phase = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               r.arg_byte       = b;
               r.arg_byte_valid = 1'b1;
               r.arg_index      = args_seen;
               data_left        = data_left - 32'd1;
               if (data_left == 32'd0) begin
                  r.arg_end = 1'b1;
                  close_argument();
               end
            end
            default: req_failed = 1'b1;
         endcase
      end
      if (last) begin
         r.status = (req_failed || parse_phase != PH_DONE) ? ST_REJECT : ST_ACCEPT;
         rearm_parse();
      end
      return r;
   endfunction

   // Drive request bytes, in bursts with random gaps when send_bursty is set
   always @(posedge clock) begin
      req_byte_type nb;
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left   <= 0;
         gap_left     <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left != 0) begin
            gap_left     <= gap_left - 1;
            req_if.valid <= 1'b0;
         end else if (request_bytes.size() != 0) begin
            nb = request_bytes.pop_front();
            req_if.data_byte <= nb.data_byte;
            req_if.last_byte <= nb.last_byte;
            req_if.valid     <= 1'b1;
            if (send_bursty && burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               gap_left   <= $urandom_range(1, 8);
            end else if (burst_left != 0) begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Stall the result channel on a rotating pattern while recv_stalls is set, reshuffled when pattern_age wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         stall_pattern <= 16'h0001;
         pattern_age   <= '0;
      end else begin
         rsp_if.ready  <= !recv_stalls || stall_pattern[0];
         stall_pattern <= (pattern_age == 5'd31) ? 16'($urandom_range(1, 65535))
                                                 : {stall_pattern[0], stall_pattern[15:1]};
         pattern_age   <= pattern_age + 5'd1;
      end
   end

   // Track register writes, predict accepted bytes, check accepted results
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         arg_limit_reg = ARG_LIMIT_RESET;
         rearm_parse();
      end else begin
         if (csr_if.valid && csr_if.ready)
            arg_limit_reg = csr_if.data;
         if (rsp_if.valid && rsp_if.ready) begin
            if (parsed_items.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with nothing outstanding:", $realtime,
                           " byte %h vld %b idx %h end %b st %0d",
                           rsp_if.arg_byte, rsp_if.arg_byte_valid,
                           rsp_if.arg_index, rsp_if.arg_end, rsp_if.status);
            end else begin
               want = parsed_items.pop_front();
               if (rsp_if.arg_byte !== want.arg_byte
                   || rsp_if.arg_byte_valid !== want.arg_byte_valid
                   || rsp_if.arg_index !== want.arg_index
                   || rsp_if.arg_end !== want.arg_end
                   || rsp_if.status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: result mismatch:", $realtime,
                              " want byte %h vld %b idx %h end %b st %0d,",
                              want.arg_byte, want.arg_byte_valid, want.arg_index,
                              want.arg_end, want.status,
                              " got byte %h vld %b idx %h end %b st %0d",
                              rsp_if.arg_byte, rsp_if.arg_byte_valid, rsp_if.arg_index,
                              rsp_if.arg_end, rsp_if.status);
               end
            end
         end
         if (req_if.valid && req_if.ready)
            parsed_items.insert(parsed_items.size(),
                                parse_request_byte(req_if.data_byte, req_if.last_byte));
      end
   end

   function automatic void append_word(ref logic [7:0] msg[$], input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         msg.insert(msg.size(), w[8*i +: 8]);
   endfunction

   // Queue one message, flagging its final byte
   function automatic void queue_message(ref logic [7:0] msg[$]);
      req_byte_type rb;
      foreach (msg[i]) begin
         rb.data_byte = msg[i];
         rb.last_byte = (i == msg.size() - 1);
         request_bytes.insert(request_bytes.size(), rb);
      end
      bytes_queued += msg.size();
   endfunction

   // Build one request: at most six arguments are laid out, long ones are cut short
   task automatic queue_request(logic [31:0] count, req_shape_type shape);
      logic [7:0]  msg[$];
      logic [31:0] len;
      int unsigned n_args;
      int unsigned n_data;
      int unsigned r;
      append_word(msg, count);
      n_args = (count > 6) ? 6 : count;
      for (int a = 0; a < n_args; a++) begin
         r = $urandom_range(0, 99);
         if (r < 55)      len = $urandom_range(0, 4);
         else if (r < 85) len = $urandom_range(5, 24);
         else if (r < 95) len = $urandom_range(25, 40);
         else             len = $urandom;
         append_word(msg, len);
         n_data = (len > 40) ? 40 : len;
         repeat (n_data) msg.insert(msg.size(), 8'($urandom));
      end
      case (shape)
         SHAPE_CUT: if (msg.size() > 1) msg = msg[0 : $urandom_range(0, msg.size() - 2)];
         SHAPE_TRAIL: repeat ($urandom_range(1, 3)) msg.insert(msg.size(), 8'($urandom));
         SHAPE_NOISE: begin
            msg.delete();
            repeat ($urandom_range(1, 12)) msg.insert(msg.size(), 8'($urandom));
         end
         default: ;
      endcase
      queue_message(msg);
   endtask

   // Hold until the sender is drained and every result has been checked
   task automatic wait_idle();
      @(negedge clock);
      while (request_bytes.size() != 0 || req_if.valid || parsed_items.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_arg_limit(logic [31:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      cur_arg_limit = value;
   endtask

   // Random requests, mostly well formed, with counts mostly small and some at or just above the current limit
   task automatic run_random(int unsigned n_bytes);
      int unsigned   target;
      int unsigned   r;
      logic [31:0]   count;
      req_shape_type shape;
      target = bytes_queued + n_bytes;
      while (bytes_queued < target) begin
         r = $urandom_range(0, 99);
         if (r < 70)      count = $urandom_range(0, 4);
         else if (r < 80) count = cur_arg_limit;
         else if (r < 88) count = cur_arg_limit + 32'd1;
         else             count = $urandom;
         r = $urandom_range(0, 99);
         if (r < 70)      shape = SHAPE_WELL;
         else if (r < 80) shape = SHAPE_CUT;
         else if (r < 90) shape = SHAPE_TRAIL;
         else             shape = SHAPE_NOISE;
         queue_request(count, shape);
      end
      wait_idle();
   endtask

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [7:0] msg[$];
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.last_byte = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.data      = '0;
      mismatch_count   = 0;
      bytes_queued     = 0;
      cur_arg_limit    = ARG_LIMIT_RESET;
      send_bursty      = 1'b1;
      recv_stalls      = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Zero count: accepted on the fourth byte
      append_word(msg, 32'd0);
      queue_message(msg);
      // Two arguments, one empty and one holding a single byte
      msg.delete();
      append_word(msg, 32'd2);
      append_word(msg, 32'd0);
      append_word(msg, 32'd1);
      msg.insert(msg.size(), 8'hff);
      queue_message(msg);
      // Request that ends inside its count
      msg.delete();
      msg.insert(msg.size(), 8'h00);
      queue_message(msg);
      // Bytes after the final argument, the second one ignored
      msg.delete();
      append_word(msg, 32'd0);
      msg.insert(msg.size(), 8'h00);
      msg.insert(msg.size(), 8'hff);
      queue_message(msg);
      // Count one above the reset limit
      msg.delete();
      append_word(msg, ARG_LIMIT_RESET + 32'd1);
      queue_message(msg);
      wait_idle();
      run_random(400);

      // Smallest limit, no idling on either side
      send_bursty = 1'b0;
      recv_stalls = 1'b0;
      write_arg_limit(32'd0);
      run_random(250);

      // Largest limit, bursty sender only
      send_bursty = 1'b1;
      write_arg_limit(32'hffff_ffff);
      run_random(350);

      // Small limit, stalling receiver only
      send_bursty = 1'b0;
      recv_stalls = 1'b1;
      write_arg_limit(32'd3);
      run_random(350);

      // Random small limit, both sides idle
      send_bursty = 1'b1;
      write_arg_limit($urandom_range(1, 8));
      run_random(350);

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && parsed_items.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
